@@ rtl/core/ttyld_pkg.sv @@
// ----------------------------------------------------------------------------
// ttyld_pkg
// Shared constants, codes and control/status types for the terminal line
// discipline.
// ----------------------------------------------------------------------------
package ttyld_pkg;

  localparam int LINE_LEN_DEF = 32;

  localparam logic [7:0] BYTE_NL = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LINE   = 2'd0;
  localparam kind_t KIND_RUBOUT = 2'd1;
  localparam kind_t KIND_READER = 2'd2;
  localparam kind_t KIND_SIGNAL = 2'd3;

  typedef logic [1:0] sig_t;
  localparam sig_t SIG_QUIT = 2'd0;
  localparam sig_t SIG_INTR = 2'd1;
  localparam sig_t SIG_SUSP = 2'd2;

  typedef logic [5:0] count_t;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IO_FLAGS    = 3'd0;
  localparam cfg_idx_t CFG_LOCAL_FLAGS = 3'd1;
  localparam cfg_idx_t CFG_ERASE       = 3'd2;
  localparam cfg_idx_t CFG_KILL        = 3'd3;
  localparam cfg_idx_t CFG_EOL         = 3'd4;
  localparam cfg_idx_t CFG_INTR        = 3'd5;
  localparam cfg_idx_t CFG_QUIT        = 3'd6;
  localparam cfg_idx_t CFG_SUSP        = 3'd7;

  localparam logic [6:0] IO_FLAGS_RST    = 7'd18;
  localparam logic [5:0] LOCAL_FLAGS_RST = 6'd47;
  localparam logic [7:0] ERASE_RST       = 8'd8;
  localparam logic [7:0] KILL_RST        = 8'd1;
  localparam logic [7:0] EOL_RST         = 8'd2;
  localparam logic [7:0] INTR_RST        = 8'd3;
  localparam logic [7:0] QUIT_RST        = 8'd28;
  localparam logic [7:0] SUSP_RST        = 8'd26;

  // result source for the output register
  typedef logic [1:0] res_sel_t;
  localparam res_sel_t RES_ECHO   = 2'd0;
  localparam res_sel_t RES_FLUSH  = 2'd1;
  localparam res_sel_t RES_SIGNAL = 2'd2;
  localparam res_sel_t RES_READER = 2'd3;

  // line length update
  typedef logic [1:0] len_op_t;
  localparam len_op_t LEN_HOLD  = 2'd0;
  localparam len_op_t LEN_DEC   = 2'd1;
  localparam len_op_t LEN_CLR   = 2'd2;
  localparam len_op_t LEN_STORE = 2'd3;

  typedef struct packed {
    logic     take;
    logic     load;
    res_sel_t sel;
    logic     last;
    logic     idx_clr;
    logic     idx_inc;
    len_op_t  len_op;
  } cmd_t;

  typedef struct packed {
    logic tx;
    logic canon;
    logic ignore;
    logic echo_en;
    logic act_nleol;
    logic act_store;
    logic act_sig;
    logic act_erase;
    logic act_kill;
    logic full;
    logic out_free;
    logic idx_end;
  } stat_t;

endpackage

@@ rtl/core/ttyld_datapath.sv @@
// ----------------------------------------------------------------------------
// ttyld_datapath
// Config registers, item registers, byte mapping and decode, line store,
// flush read pointer and the output register.
// ----------------------------------------------------------------------------
module ttyld_datapath #(
  parameter int LINE_LEN = ttyld_pkg::LINE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  ttyld_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                command,
  input  logic [7:0]          data_byte,
  input  ttyld_pkg::cmd_t     cmd,
  output ttyld_pkg::stat_t    stat,
  input  logic                out_stall,
  output logic                out_valid,
  output ttyld_pkg::kind_t    kind,
  output logic [7:0]          out_byte,
  output ttyld_pkg::count_t   rubout_count,
  output ttyld_pkg::sig_t     signal_code,
  output logic                last
);

  localparam int LenW = $clog2(LINE_LEN + 1);
  localparam int IdxW = $clog2(LINE_LEN);

  logic [6:0] io_flags;
  logic [5:0] local_flags;
  logic [7:0] erase_char, kill_char, eol_char, intr_char, quit_char, susp_char;

  logic            item_tx;
  logic [7:0]      item_byte;
  logic [LenW-1:0] len;
  logic [IdxW-1:0] idx;
  logic [7:0]      mem [LINE_LEN];
  logic [7:0]      rd_data;

  logic [7:0]      in_map, in_byte, out_map, c;
  logic            erase_e, kill_k, echo_canon;
  logic            is_nleol, is_erase, is_kill, is_sig;
  ttyld_pkg::sig_t sig_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      io_flags    <= ttyld_pkg::IO_FLAGS_RST;
      local_flags <= ttyld_pkg::LOCAL_FLAGS_RST;
      erase_char  <= ttyld_pkg::ERASE_RST;
      kill_char   <= ttyld_pkg::KILL_RST;
      eol_char    <= ttyld_pkg::EOL_RST;
      intr_char   <= ttyld_pkg::INTR_RST;
      quit_char   <= ttyld_pkg::QUIT_RST;
      susp_char   <= ttyld_pkg::SUSP_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        ttyld_pkg::CFG_IO_FLAGS:    io_flags    <= cfg_data[6:0];
        ttyld_pkg::CFG_LOCAL_FLAGS: local_flags <= cfg_data[5:0];
        ttyld_pkg::CFG_ERASE:       erase_char  <= cfg_data;
        ttyld_pkg::CFG_KILL:        kill_char   <= cfg_data;
        ttyld_pkg::CFG_EOL:         eol_char    <= cfg_data;
        ttyld_pkg::CFG_INTR:        intr_char   <= cfg_data;
        ttyld_pkg::CFG_QUIT:        quit_char   <= cfg_data;
        ttyld_pkg::CFG_SUSP:        susp_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_tx   <= command;
      item_byte <= data_byte;
    end
  end

  // mapping
  always_comb begin
    if (io_flags[0] && item_byte == ttyld_pkg::BYTE_NL) in_map = ttyld_pkg::BYTE_CR;
    else if (io_flags[1] && item_byte == ttyld_pkg::BYTE_CR) in_map = ttyld_pkg::BYTE_NL;
    else in_map = item_byte;
    in_byte = io_flags[3] ? {1'b0, in_map[6:0]} : in_map;

    out_map = item_byte;
    if (io_flags[4]) begin
      if (io_flags[5] && item_byte == ttyld_pkg::BYTE_NL) out_map = ttyld_pkg::BYTE_CR;
      else if (io_flags[6] && item_byte == ttyld_pkg::BYTE_CR) out_map = ttyld_pkg::BYTE_NL;
    end

    if (item_tx) c = out_map;
    else if (local_flags[0]) c = in_byte;
    else c = item_byte;
  end

  // canonical decode
  always_comb begin
    erase_e    = (in_byte == erase_char) && local_flags[2];
    kill_k     = (in_byte == kill_char) && local_flags[3];
    if (erase_e || kill_k) echo_canon = (len != '0);
    else echo_canon = local_flags[1] || (in_byte == ttyld_pkg::BYTE_NL && local_flags[4]);

    is_nleol = (in_byte == ttyld_pkg::BYTE_NL) || (in_byte == eol_char);
    is_erase = !is_nleol && (in_byte == erase_char);
    is_kill  = !is_nleol && !is_erase && (in_byte == kill_char);
    is_sig   = !is_nleol && !is_erase && !is_kill && local_flags[5] &&
               (in_byte == quit_char || in_byte == intr_char || in_byte == susp_char);
    if (in_byte == quit_char) sig_code = ttyld_pkg::SIG_QUIT;
    else if (in_byte == intr_char) sig_code = ttyld_pkg::SIG_INTR;
    else sig_code = ttyld_pkg::SIG_SUSP;
  end

  always_comb begin
    stat.tx        = item_tx;
    stat.canon     = local_flags[0];
    stat.ignore    = !item_tx && local_flags[0] && io_flags[2] &&
                     (in_map == ttyld_pkg::BYTE_CR);
    if (item_tx) stat.echo_en = 1'b1;
    else if (local_flags[0]) stat.echo_en = echo_canon;
    else stat.echo_en = local_flags[1];
    stat.act_nleol = is_nleol;
    stat.act_erase = is_erase;
    stat.act_kill  = is_kill;
    stat.act_sig   = is_sig;
    stat.act_store = !is_nleol && !is_erase && !is_kill && !is_sig;
    stat.full      = (len == LenW'(LINE_LEN));
    stat.out_free  = !out_valid || !out_stall;
    stat.idx_end   = (LenW'(idx) == LenW'(len - 1'b1));
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.len_op == ttyld_pkg::LEN_STORE) mem[len[IdxW-1:0]] <= c;
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      unique case (cmd.len_op)
        ttyld_pkg::LEN_HOLD:  len <= len;
        ttyld_pkg::LEN_DEC:   if (len != '0) len <= len - 1'b1;
        ttyld_pkg::LEN_CLR:   len <= '0;
        ttyld_pkg::LEN_STORE: len <= len + 1'b1;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last         <= cmd.last;
      out_byte     <= '0;
      rubout_count <= '0;
      signal_code  <= ttyld_pkg::SIG_QUIT;
      unique case (cmd.sel)
        ttyld_pkg::RES_ECHO: begin
          if (!item_tx && local_flags[0] && (erase_e || kill_k)) begin
            kind         <= ttyld_pkg::KIND_RUBOUT;
            rubout_count <= erase_e ? ttyld_pkg::count_t'(1) : ttyld_pkg::count_t'(len);
          end else begin
            kind     <= ttyld_pkg::KIND_LINE;
            out_byte <= c;
          end
        end
        ttyld_pkg::RES_FLUSH: begin
          kind     <= ttyld_pkg::KIND_READER;
          out_byte <= rd_data;
        end
        ttyld_pkg::RES_SIGNAL: begin
          kind        <= ttyld_pkg::KIND_SIGNAL;
          signal_code <= sig_code;
        end
        ttyld_pkg::RES_READER: begin
          kind     <= ttyld_pkg::KIND_READER;
          out_byte <= c;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/ttyld_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttyld_ctrl
// Sequencer: takes one item, then steps through echo, line edit, flush,
// signal and reader phases, issuing one result per output transfer.
// ----------------------------------------------------------------------------
module ttyld_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ttyld_pkg::stat_t stat,
  output ttyld_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_ECHO     = 4'd2;
  localparam logic [3:0] S_ACT      = 4'd3;
  localparam logic [3:0] S_STORE    = 4'd4;
  localparam logic [3:0] S_PRE_RD   = 4'd5;
  localparam logic [3:0] S_PRE_OUT  = 4'd6;
  localparam logic [3:0] S_POST_RD  = 4'd7;
  localparam logic [3:0] S_POST_OUT = 4'd8;
  localparam logic [3:0] S_SIGNAL   = 4'd9;
  localparam logic [3:0] S_READER   = 4'd10;

  logic [3:0] state, state_next;
  logic       follows;

  assign in_stall = (state != S_IDLE);

  // does anything come after the echo result
  assign follows = !stat.tx && (!stat.canon || stat.act_nleol || stat.act_sig ||
                                (stat.act_store && stat.full));

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.ignore) state_next = S_IDLE;
        else if (stat.echo_en) state_next = S_ECHO;
        else state_next = S_ACT;
      end
      S_ECHO: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = ttyld_pkg::RES_ECHO;
          cmd.last   = !follows;
          state_next = stat.tx ? S_IDLE : S_ACT;
        end
      end
      S_ACT: begin
        if (stat.tx) begin
          state_next = S_IDLE;
        end else if (!stat.canon) begin
          state_next = S_READER;
        end else if (stat.act_erase) begin
          cmd.len_op = ttyld_pkg::LEN_DEC;
          state_next = S_IDLE;
        end else if (stat.act_kill) begin
          cmd.len_op = ttyld_pkg::LEN_CLR;
          state_next = S_IDLE;
        end else if (stat.act_sig) begin
          state_next = S_SIGNAL;
        end else if (stat.full) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_PRE_RD;
        end else begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.len_op = ttyld_pkg::LEN_STORE;
        if (stat.act_nleol) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_POST_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PRE_RD: state_next = S_PRE_OUT;
      S_PRE_OUT: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = ttyld_pkg::RES_FLUSH;
          cmd.last = stat.idx_end && !stat.act_nleol;
          if (stat.idx_end) begin
            cmd.len_op = ttyld_pkg::LEN_CLR;
            state_next = S_STORE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_PRE_RD;
          end
        end
      end
      S_POST_RD: state_next = S_POST_OUT;
      S_POST_OUT: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = ttyld_pkg::RES_FLUSH;
          cmd.last = stat.idx_end;
          if (stat.idx_end) begin
            cmd.len_op = ttyld_pkg::LEN_CLR;
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_POST_RD;
          end
        end
      end
      S_SIGNAL: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = ttyld_pkg::RES_SIGNAL;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READER: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = ttyld_pkg::RES_READER;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/tty_canonical_line_discipline.sv @@
// ----------------------------------------------------------------------------
// tty_canonical_line_discipline
// Each input transfer is taken into the item registers and decoded, and
// each result is registered. A stored byte sent on a line flush passes a
// read state and then an output state (store read port is registered, one
// byte per read cycle). in_stall stays high until the item is finished.
// Reset: config registers to defaults, line length zero; store not cleared.
// ----------------------------------------------------------------------------
module tty_canonical_line_discipline #(
  parameter int LINE_LEN = ttyld_pkg::LINE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  ttyld_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output ttyld_pkg::kind_t    kind,
  output logic [7:0]          out_byte,
  output ttyld_pkg::count_t   rubout_count,
  output ttyld_pkg::sig_t     signal_code,
  output logic                last
);

  ttyld_pkg::cmd_t  cmd;
  ttyld_pkg::stat_t stat;

  ttyld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttyld_datapath #(
    .LINE_LEN (LINE_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .out_byte     (out_byte),
    .rubout_count (rubout_count),
    .signal_code  (signal_code),
    .last         (last)
  );

endmodule

@@ test/ttyld_checker.sv @@
// ----------------------------------------------------------------------------
// ttyld_checker
// Watches the configuration port and both channels of the terminal line
// discipline. It keeps its own copy of the registers and the line store,
// works out the results of every input transfer, and compares each output
// transfer with the oldest outstanding result.
// ----------------------------------------------------------------------------
module ttyld_checker
  import ttyld_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  cfg_idx_t   cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       command,
  input  logic [7:0] data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  kind_t      kind,
  input  logic [7:0] out_byte,
  input  count_t     rubout_count,
  input  sig_t       signal_code,
  input  logic       last,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    count_t     count;
    sig_t       sig;
    logic       last;
  } tty_result_t;

  logic [6:0] io_flags;
  logic [5:0] local_flags;
  logic [7:0] erase_char, kill_char, eol_char, intr_char, quit_char, susp_char;

  logic [7:0] line_buf [LINE_LEN];
  int         line_len;

  tty_result_t item_results[$];
  tty_result_t pending_results[$];

  function automatic void emit(kind_t k, logic [7:0] c, count_t n, sig_t s);
    tty_result_t r;
    r.kind  = k;
    r.ch    = c;
    r.count = n;
    r.sig   = s;
    r.last  = 1'b0;
    item_results.push_back(r);
  endfunction

  function automatic void flush_line();
    for (int i = 0; i < line_len; i++) emit(KIND_READER, line_buf[i], '0, '0);
    line_len = 0;
  endfunction

  function automatic void store_char(logic [7:0] c);
    if (line_len >= LINE_LEN) flush_line();
    line_buf[line_len] = c;
    line_len++;
  endfunction

  // Results of one transfer, appended to the outstanding queue.
  function automatic void process_byte(logic transmit, logic [7:0] b);
    logic [7:0] c;
    c = b;
    item_results.delete();
    if (transmit) begin
      if (io_flags[4]) begin
        if (io_flags[5] && c == BYTE_NL) c = BYTE_CR;
        else if (io_flags[6] && c == BYTE_CR) c = BYTE_NL;
      end
      emit(KIND_LINE, c, '0, '0);
    end else if (local_flags[0]) begin
      if (io_flags[0] && c == BYTE_NL) c = BYTE_CR;
      else if (io_flags[1] && c == BYTE_CR) c = BYTE_NL;
      if (!(io_flags[2] && c == BYTE_CR)) begin
        if (io_flags[3]) c[7] = 1'b0;
        // echo
        if (c == erase_char && local_flags[2]) begin
          if (line_len != 0) emit(KIND_RUBOUT, '0, count_t'(1), '0);
        end else if (c == kill_char && local_flags[3]) begin
          if (line_len != 0) emit(KIND_RUBOUT, '0, count_t'(line_len), '0);
        end else if (local_flags[1] || (c == BYTE_NL && local_flags[4])) begin
          emit(KIND_LINE, c, '0, '0);
        end
        // edit
        if (c == BYTE_NL || c == eol_char) begin
          store_char(c);
          flush_line();
        end else if (c == erase_char) begin
          if (line_len != 0) line_len--;
        end else if (c == kill_char) begin
          line_len = 0;
        end else if (local_flags[5] && c == quit_char) begin
          emit(KIND_SIGNAL, '0, '0, SIG_QUIT);
        end else if (local_flags[5] && c == intr_char) begin
          emit(KIND_SIGNAL, '0, '0, SIG_INTR);
        end else if (local_flags[5] && c == susp_char) begin
          emit(KIND_SIGNAL, '0, '0, SIG_SUSP);
        end else begin
          store_char(c);
        end
      end
    end else begin
      if (local_flags[1]) emit(KIND_LINE, c, '0, '0);
      emit(KIND_READER, c, '0, '0);
    end
    if (item_results.size() != 0) item_results[$].last = 1'b1;
    foreach (item_results[i]) pending_results.push_back(item_results[i]);
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    tty_result_t got, want;
    if (rst) begin
      io_flags    = IO_FLAGS_RST;
      local_flags = LOCAL_FLAGS_RST;
      erase_char  = ERASE_RST;
      kill_char   = KILL_RST;
      eol_char    = EOL_RST;
      intr_char   = INTR_RST;
      quit_char   = QUIT_RST;
      susp_char   = SUSP_RST;
      line_len    = 0;
      pending_results.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_IO_FLAGS:    io_flags    = cfg_data[6:0];
          CFG_LOCAL_FLAGS: local_flags = cfg_data[5:0];
          CFG_ERASE:       erase_char  = cfg_data;
          CFG_KILL:        kill_char   = cfg_data;
          CFG_EOL:         eol_char    = cfg_data;
          CFG_INTR:        intr_char   = cfg_data;
          CFG_QUIT:        quit_char   = cfg_data;
          CFG_SUSP:        susp_char   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) process_byte(command, data_byte);
      if (out_valid && !out_stall) begin
        got = {kind, out_byte, rubout_count, signal_code, last};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual kind=%0d byte=%02h",
                   $time, got.kind, got.ch, " count=%0d sig=%0d last=%0b",
                   got.count, got.sig, got.last);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected kind=%0d byte=%02h count=%0d sig=%0d last=%0b",
                     $time, want.kind, want.ch, want.count, want.sig, want.last);
            $display("%0t:           actual kind=%0d byte=%02h count=%0d sig=%0d last=%0b",
                     $time, got.kind, got.ch, got.count, got.sig, got.last);
            errors++;
          end
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the terminal line discipline: a directed opening at reset
// settings, then line-shaped random traffic with edits, signals and noise
// across several register settings and idle patterns. Checking is done by
// ttyld_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttyld_pkg::*;

  localparam logic CMD_RX = 1'b0;
  localparam logic CMD_TX = 1'b1;

  logic       clk;
  logic       rst;
  logic       cfg_write_en;
  cfg_idx_t   cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       command;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  kind_t      kind;
  logic [7:0] out_byte;
  count_t     rubout_count;
  sig_t       signal_code;
  logic       last;

  int         chk_errors;
  int         pending;
  int         drain_errors = 0;
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic [7:0] ctl [8];

  tty_canonical_line_discipline dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .rubout_count (rubout_count),
    .signal_code  (signal_code),
    .last         (last)
  );

  ttyld_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .rubout_count (rubout_count),
    .signal_code  (signal_code),
    .last         (last),
    .errors       (chk_errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(input logic cmd, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result has been seen.
  task automatic wait_quiet();
    int n;
    @(negedge clk);
    in_valid <= 1'b0;
    n = 0;
    while (pending != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    if (pending != 0) begin
      $display("%0t: drain: expected 0 outstanding, actual %0d", $time, pending);
      drain_errors++;
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    ctl[idx] = val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic configure(input int p);
    logic [7:0] v [8];
    case (p)
      1:       v = '{8'h7F, 8'h3F, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE};
      2:       v = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h20, 8'h0A};
      3:       v = '{8'h32, 8'h31, 8'h7F, 8'h15, 8'h04, 8'h03, 8'h1C, 8'h1A};
      4:       v = '{8'h51, 8'h03, 8'h08, 8'h15, 8'h00, 8'h03, 8'h1C, 8'h1A};
      5:       v = '{8'h0C, 8'h2F, 8'h88, 8'h0D, 8'h0A, 8'h83, 8'h9C, 8'h9A};
      6:       v = '{8'h10, 8'h02, 8'h08, 8'h15, 8'h04, 8'h03, 8'h1C, 8'h1A};
      default: foreach (v[i]) v[i] = 8'($urandom_range(255));
    endcase
    foreach (v[i]) write_reg(cfg_idx_t'(i), v[i]);
  endtask

  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(99);
    if (r < 72) return 8'($urandom_range(255));
    if (r < 80) return ctl[CFG_ERASE];
    if (r < 84) return ctl[CFG_KILL];
    if (r < 87) return ctl[CFG_INTR];
    if (r < 90) return ctl[CFG_QUIT];
    if (r < 93) return ctl[CFG_SUSP];
    return 8'($urandom_range(31));
  endfunction

  function automatic logic [7:0] tx_byte();
    int r;
    r = $urandom_range(9);
    if (r < 3) return BYTE_NL;
    if (r < 6) return BYTE_CR;
    return 8'($urandom_range(255));
  endfunction

  // Mostly whole lines with random content; some long enough to overflow
  // the store, some pure noise.
  task automatic run_random(input int budget);
    int start, n, r;
    start = items_sent;
    while (items_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 10) begin
        n = $urandom_range(6, 1);
        repeat (n) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        if (r < 20) begin
          n = $urandom_range(40, 33);
          repeat (n) send_item(CMD_RX, 8'($urandom_range(255)));
        end else begin
          n = $urandom_range(8);
          repeat (n) begin
            if ($urandom_range(99) < 8) send_item(CMD_TX, tx_byte());
            else send_item(CMD_RX, body_byte());
          end
        end
        r = $urandom_range(3);
        if (r < 2) send_item(CMD_RX, BYTE_NL);
        else if (r == 2) send_item(CMD_RX, BYTE_CR);
        else send_item(CMD_RX, ctl[CFG_EOL]);
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = CFG_IO_FLAGS;
    cfg_data     = '0;
    in_valid     = 1'b0;
    command      = CMD_RX;
    data_byte    = '0;
    ctl[CFG_IO_FLAGS]    = 8'(IO_FLAGS_RST);
    ctl[CFG_LOCAL_FLAGS] = 8'(LOCAL_FLAGS_RST);
    ctl[CFG_ERASE]       = ERASE_RST;
    ctl[CFG_KILL]        = KILL_RST;
    ctl[CFG_EOL]         = EOL_RST;
    ctl[CFG_INTR]        = INTR_RST;
    ctl[CFG_QUIT]        = QUIT_RST;
    ctl[CFG_SUSP]        = SUSP_RST;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 49;
      end else if (p < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p != 0) begin
        wait_quiet();
        configure(p);
      end else begin
        send_item(CMD_TX, BYTE_NL);
        send_item(CMD_TX, BYTE_CR);
        send_item(CMD_TX, 8'h00);
        send_item(CMD_TX, 8'hFF);
        send_item(CMD_RX, ERASE_RST);   // erase on empty line
        send_item(CMD_RX, KILL_RST);    // kill on empty line
        send_item(CMD_RX, 8'h61);
        send_item(CMD_RX, 8'hFF);
        send_item(CMD_RX, 8'h00);
        send_item(CMD_RX, ERASE_RST);
        send_item(CMD_RX, KILL_RST);
        send_item(CMD_RX, INTR_RST);
        send_item(CMD_RX, QUIT_RST);
        send_item(CMD_RX, SUSP_RST);
        send_item(CMD_RX, 8'h7A);
        send_item(CMD_RX, BYTE_CR);     // mapped to newline
        send_item(CMD_RX, 8'h42);
        send_item(CMD_RX, EOL_RST);
        send_item(CMD_RX, BYTE_NL);
      end
      run_random(8);
      wait_quiet();
      run_random(8);
    end
    wait_quiet();

    if (chk_errors == 0 && drain_errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
